[hw/rtl/assert_macros.svh]
// Assertion macros shared by the fader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition holds in the cycle after an antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mlf_pkg.sv]
// Types, constants and command codes of the multichannel LED fader.
package mlf_pkg;

	localparam int CHANNELS         = 5;
	localparam int MAX_LEVEL        = 100;
	localparam int FULL_BRIGHTNESS  = 100;
	localparam int PWM_FULL_SCALE   = 5000;
	localparam int FADE_STEPS_RESET = 50;

	localparam int CMD_W  = 2;
	localparam int CH_W   = 3;
	localparam int LVL_W  = 7;
	localparam int STEP_W = 8;
	localparam int PWM_W  = 13;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// current*brightness, then divided by FULL_BRIGHTNESS through a reciprocal
	localparam int GPROD_W      = 2 * LVL_W;
	localparam int GOAL_SHIFT   = 24;
	localparam int GOAL_RECIP   = (2**GOAL_SHIFT + FULL_BRIGHTNESS - 1) / FULL_BRIGHTNESS;
	localparam int GOAL_RECIP_W = $clog2(GOAL_RECIP + 1);

	// applied*PWM_FULL_SCALE, then divided by MAX_LEVEL through a reciprocal
	localparam int PPROD_W     = LVL_W + $clog2(PWM_FULL_SCALE + 1);
	localparam int PWM_SHIFT   = 26;
	localparam int PWM_RECIP   = (2**PWM_SHIFT + MAX_LEVEL - 1) / MAX_LEVEL;
	localparam int PWM_RECIP_W = $clog2(PWM_RECIP + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 2'd0,
		CMD_SET_TARGET = 2'd1,
		CMD_SET_BRIGHT = 2'd2,
		CMD_ARM        = 2'd3
	} cmd_code_t;

	typedef enum logic {
		DIV_TARGET = 1'b0,
		DIV_GOAL   = 1'b1
	} div_sel_t;

	typedef struct packed {
		cmd_code_t         command;
		logic [CH_W-1:0]   channel_index;
		logic [LVL_W-1:0]  level;
	} fader_cmd_t;

	typedef struct packed {
		logic [CH_W-1:0]   out_channel;
		logic [PWM_W-1:0]  pwm_duty;
		logic [LVL_W-1:0]  scaled_level;
		logic              fade_done;
		logic              last;
	} fader_res_t;

	typedef struct packed {
		logic     capture;
		logic     set_target;
		logic     set_bright;
		logic     ch_clr;
		logic     ch_inc;
		logic     tick_begin;
		logic     mul_cur;
		logic     mul_goal;
		logic     arm_mark;
		logic     dec;
		logic     div_start;
		div_sel_t div_sel;
		logic     upd_cur;
		logic     upd_app;
		logic     mul_pwm;
		logic     pwm_fin;
		logic     emit;
	} ctrl_t;

	typedef struct packed {
		cmd_code_t command;
		logic      fading;
		logic      ch_last;
		logic      div_done;
		logic      div_busy;
		logic      app_eq;
		logic      out_free;
	} stat_t;

endpackage

[hw/rtl/mlf_div.sv]
// Iterative signed floor divider, one quotient bit per cycle.
module mlf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [mlf_pkg::LVL_W:0]   num,
	input  logic [mlf_pkg::STEP_W-1:0]  den,
	output logic                        busy,
	output logic                        done,
	output logic signed [mlf_pkg::LVL_W+1:0] quot
);
	import mlf_pkg::*;

	localparam int QW  = LVL_W + 1;
	localparam int CNT_W = $clog2(QW);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [STEP_W-1:0] rem_q;
	logic [QW-1:0]     dvd_q;
	logic [STEP_W-1:0] den_q;

	logic [QW-1:0]     mag;
	logic [STEP_W:0]   trial;
	logic [STEP_W:0]   diff;
	logic              ge;
	logic              rem_nz;
	logic [QW:0]       q_ext;
	logic [QW:0]       q_neg;

	always_comb begin
		mag    = num[LVL_W] ? QW'(-num) : QW'(num);
		trial  = {rem_q, dvd_q[QW-1]};
		diff   = trial - {1'b0, den_q};
		ge     = trial >= {1'b0, den_q};
		rem_nz = rem_q != '0;
		q_ext  = {1'b0, dvd_q};
		// floor for negative: -q when exact, otherwise -q-1 which is ~q
		q_neg  = ~q_ext + {{QW{1'b0}}, !rem_nz};
		quot   = $signed(neg_q ? q_neg : q_ext);
	end

	assign busy = busy_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[LVL_W];
			rem_q <= '0;
			dvd_q <= mag;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
			dvd_q <= {dvd_q[QW-2:0], ge};
		end
	end

endmodule

[hw/rtl/mlf_dp.sv]
// Fader datapath: channel state, multipliers, divider and result register.
module mlf_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mlf_pkg::ctrl_t               ctl,
	output mlf_pkg::stat_t               sts,
	input  mlf_pkg::fader_cmd_t          cmd,
	input  logic                         cfg_valid,
	input  logic [mlf_pkg::STEP_W-1:0]   cfg_data,
	input  logic                         res_stall,
	output logic                         res_valid,
	output mlf_pkg::fader_res_t          res
);
	import mlf_pkg::*;

	localparam int GMUL_W = GPROD_W + GOAL_RECIP_W;
	localparam int GOAL_W = GMUL_W - GOAL_SHIFT;
	localparam int PMUL_W = PPROD_W + PWM_RECIP_W;

	logic [LVL_W-1:0]  target_q  [CHANNELS];
	logic [LVL_W-1:0]  current_q [CHANNELS];
	logic [LVL_W-1:0]  applied_q [CHANNELS];
	logic [STEP_W-1:0] steps_q   [CHANNELS];
	logic [LVL_W-1:0]  bright_q;
	logic [STEP_W-1:0] fade_steps_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic              done_q;
	logic              res_valid_q;

	fader_cmd_t        item_q;
	logic [STEP_W-1:0] div_q;
	logic [GPROD_W-1:0] gprod_q;
	logic [LVL_W-1:0]  goal_q;
	logic [PPROD_W-1:0] pprod_q;
	logic [PWM_W-1:0]  pwm_q;
	fader_res_t        res_q;

	logic [LVL_W-1:0]  tgt, cur, app;
	logic [STEP_W-1:0] steps;
	logic [STEP_W-1:0] arm_n;
	logic [LVL_W-1:0]  sat_lvl, sat_bright;
	logic              tgt_ok;
	logic [GMUL_W-1:0] gmul;
	logic [GOAL_W-1:0] goal_wide;
	logic [LVL_W-1:0]  goal_sat;
	logic [PMUL_W-1:0] pmul;
	logic              all_le1;
	logic              later;
	logic signed [LVL_W:0]   div_num;
	logic signed [LVL_W+1:0] quot;
	logic signed [LVL_W+1:0] cur_sum, app_sum;
	logic              div_busy, div_done;

	always_comb begin
		tgt   = target_q[ch_q];
		cur   = current_q[ch_q];
		app   = applied_q[ch_q];
		steps = steps_q[ch_q];
		arm_n = (fade_steps_q == '0) ? STEP_W'(1) : fade_steps_q;

		tgt_ok     = item_q.channel_index < CH_W'(CHANNELS);
		sat_lvl    = (item_q.level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : item_q.level;
		sat_bright = (item_q.level > LVL_W'(FULL_BRIGHTNESS)) ?
			LVL_W'(FULL_BRIGHTNESS) : item_q.level;

		gmul      = GMUL_W'(gprod_q) * GMUL_W'(GOAL_RECIP);
		goal_wide = gmul[GMUL_W-1:GOAL_SHIFT];
		goal_sat  = (goal_wide > GOAL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : goal_wide[LVL_W-1:0];
		pmul      = PMUL_W'(pprod_q) * PMUL_W'(PWM_RECIP);

		all_le1 = 1'b1;
		later   = 1'b0;
		for (int j = 0; j < CHANNELS; j++) begin
			if (steps_q[j] > STEP_W'(1))
				all_le1 = 1'b0;
			if ((CH_IDX_W'(j) > ch_q) && (steps_q[j] != '0))
				later = 1'b1;
		end

		if (ctl.div_sel == DIV_GOAL)
			div_num = $signed({1'b0, goal_q}) - $signed({1'b0, app});
		else
			div_num = $signed({1'b0, tgt}) - $signed({1'b0, cur});

		cur_sum = $signed({2'b00, cur}) + quot;
		app_sum = $signed({2'b00, app}) + quot;

		sts.command  = item_q.command;
		sts.fading   = steps != '0;
		sts.ch_last  = ch_q == CH_IDX_W'(CHANNELS - 1);
		sts.div_done = div_done;
		sts.div_busy = div_busy;
		sts.app_eq   = app == goal_q;
		sts.out_free = !res_valid_q || !res_stall;
	end

	mlf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (div_num),
		.den    (div_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				target_q[i]  <= '0;
				current_q[i] <= '0;
				applied_q[i] <= '0;
				steps_q[i]   <= '0;
			end
			bright_q     <= LVL_W'(FULL_BRIGHTNESS);
			fade_steps_q <= STEP_W'(FADE_STEPS_RESET);
			ch_q         <= '0;
			done_q       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				fade_steps_q <= cfg_data;
			if (ctl.set_target && tgt_ok)
				target_q[item_q.channel_index[CH_IDX_W-1:0]] <= sat_lvl;
			if (ctl.set_bright)
				bright_q <= sat_bright;
			if (ctl.ch_clr)
				ch_q <= '0;
			else if (ctl.ch_inc)
				ch_q <= ch_q + 1'b1;
			if (ctl.tick_begin)
				done_q <= all_le1;
			if (ctl.arm_mark && ((cur != tgt) || (app != goal_q)))
				steps_q[ch_q] <= arm_n;
			if (ctl.dec)
				steps_q[ch_q] <= steps - 1'b1;
			if (ctl.upd_cur)
				current_q[ch_q] <= cur_sum[LVL_W-1:0];
			if (ctl.upd_app)
				applied_q[ch_q] <= app_sum[LVL_W-1:0];
			// hold the result until the receiver takes it
			if (ctl.emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture)
			item_q <= cmd;
		if (ctl.dec)
			div_q <= steps;
		if (ctl.mul_cur)
			gprod_q <= GPROD_W'(cur) * GPROD_W'(bright_q);
		if (ctl.mul_goal)
			goal_q <= goal_sat;
		if (ctl.mul_pwm)
			pprod_q <= PPROD_W'(app) * PPROD_W'(PWM_FULL_SCALE);
		if (ctl.pwm_fin)
			pwm_q <= PWM_W'(pmul[PMUL_W-1:PWM_SHIFT]);
		if (ctl.emit) begin
			res_q.out_channel  <= CH_W'(ch_q);
			res_q.pwm_duty     <= pwm_q;
			res_q.scaled_level <= app;
			res_q.fade_done    <= done_q;
			res_q.last         <= !later;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[hw/rtl/mlf_ctrl.sv]
// Fader controller: sequences set, arm and tick requests over the channels.
module mlf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	output mlf_pkg::ctrl_t  ctl,
	input  mlf_pkg::stat_t  sts
);
	import mlf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ARM_MUL,
		S_ARM_GOAL,
		S_ARM_MARK,
		S_TK_CHK,
		S_TK_DIV1,
		S_TK_WAIT1,
		S_TK_MUL,
		S_TK_GOAL,
		S_TK_CMP,
		S_TK_WAIT2,
		S_TK_PWM,
		S_TK_PWM2,
		S_TK_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.command)
					CMD_SET_TARGET: begin
						ctl.set_target = 1'b1;
						state_d        = S_IDLE;
					end
					CMD_SET_BRIGHT: begin
						ctl.set_bright = 1'b1;
						state_d        = S_IDLE;
					end
					CMD_ARM: begin
						ctl.ch_clr = 1'b1;
						state_d    = S_ARM_MUL;
					end
					CMD_TICK: begin
						ctl.ch_clr     = 1'b1;
						ctl.tick_begin = 1'b1;
						state_d        = S_TK_CHK;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ARM_MUL: begin
				ctl.mul_cur = 1'b1;
				state_d     = S_ARM_GOAL;
			end
			S_ARM_GOAL: begin
				ctl.mul_goal = 1'b1;
				state_d      = S_ARM_MARK;
			end
			S_ARM_MARK: begin
				ctl.arm_mark = 1'b1;
				if (sts.ch_last) begin
					state_d = S_IDLE;
				end else begin
					ctl.ch_inc = 1'b1;
					state_d    = S_ARM_MUL;
				end
			end
			S_TK_CHK: begin
				if (sts.fading) begin
					ctl.dec = 1'b1;
					state_d = S_TK_DIV1;
				end else if (sts.ch_last) begin
					state_d = S_IDLE;
				end else begin
					ctl.ch_inc = 1'b1;
				end
			end
			S_TK_DIV1: begin
				ctl.div_start = 1'b1;
				ctl.div_sel   = DIV_TARGET;
				state_d       = S_TK_WAIT1;
			end
			S_TK_WAIT1: begin
				if (sts.div_done) begin
					ctl.upd_cur = 1'b1;
					state_d     = S_TK_MUL;
				end
			end
			S_TK_MUL: begin
				ctl.mul_cur = 1'b1;
				state_d     = S_TK_GOAL;
			end
			S_TK_GOAL: begin
				ctl.mul_goal = 1'b1;
				state_d      = S_TK_CMP;
			end
			S_TK_CMP: begin
				// skip the second step when the scaled level already sits on its goal
				if (sts.app_eq) begin
					state_d = S_TK_PWM;
				end else begin
					ctl.div_start = 1'b1;
					ctl.div_sel   = DIV_GOAL;
					state_d       = S_TK_WAIT2;
				end
			end
			S_TK_WAIT2: begin
				if (sts.div_done) begin
					ctl.upd_app = 1'b1;
					state_d     = S_TK_PWM;
				end
			end
			S_TK_PWM: begin
				ctl.mul_pwm = 1'b1;
				state_d     = S_TK_PWM2;
			end
			S_TK_PWM2: begin
				ctl.pwm_fin = 1'b1;
				state_d     = S_TK_EMIT;
			end
			S_TK_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (sts.ch_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.ch_inc = 1'b1;
						state_d    = S_TK_CHK;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = state_q != S_IDLE;

endmodule

[hw/rtl/multichannel_led_fader_core.sv]
// Top level of the multichannel LED fader.
//
// Request channel (cmd_valid, cmd_stall, cmd): each request is a tick, a
// channel target write, a brightness write or an arm. A request is taken at
// an edge with cmd_valid high and cmd_stall low; cmd_stall stays high while a
// request is worked on, so one request is handled at a time.
// Result channel (res_valid, res_stall, res): a tick gives one result per
// fading channel in channel order; the final one has last set. A tick uses
// the bit-serial divider once or twice per fading channel.
// A stalled result waits in the output register; the walk over the channels
// pauses at the next result until the receiver takes the pending one.
// Configuration (cfg_valid, cfg_ready, cfg_data) writes the fade step count;
// cfg_ready is always high. Reset clears all levels and steps, sets full
// brightness and a fade of 50 ticks, and leaves the block ready at once.
`include "assert_macros.svh"

module multichannel_led_fader_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  mlf_pkg::fader_cmd_t         cmd,
	output logic                        res_valid,
	input  logic                        res_stall,
	output mlf_pkg::fader_res_t         res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mlf_pkg::STEP_W-1:0]  cfg_data
);
	import mlf_pkg::*;

	ctrl_t ctl;
	stat_t sts;

	assign cfg_ready = 1'b1;

	mlf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	mlf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

	`CHK_NEXT(a_accept_busy, cmd_valid && !cmd_stall, cmd_stall, "request taken but block not busy")
	`CHK_ALWAYS(a_emit_free, !ctl.emit || sts.out_free, "result loaded over a pending one")
	`CHK_ALWAYS(a_idle_div, cmd_stall || !sts.div_busy, "divider running while idle")

endmodule
